// File: rtl/pof_pkg.sv
// pof_pkg: shared types for the prime / Fibonacci classifier.
// Command and status groups passed between pof_ctrl and pof_dp.
// No dependencies.
`default_nettype none

package pof_pkg;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;        // capture a new item and initialise the iterators
		logic step_fib;    // advance the Fibonacci pair by one term
		logic start_rem;   // launch a remainder n % d
		logic next_div;    // move to the next trial divisor
		logic set_verdict; // write the result register
		logic verdict_bit; // value written on set_verdict
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic sel_fib;   // item asks for the Fibonacci test
		logic neg;       // value is negative
		logic lt2;       // magnitude below two
		logic sq_gt_n;   // d*d exceeds n, no divisor left to try
		logic a_ge_n;    // Fibonacci term has reached or passed n
		logic a_eq_n;    // Fibonacci term equals n
		logic rem_busy;  // remainder unit still iterating
		logic rem_zero;  // last remainder was zero
	} status_t;

endpackage

`default_nettype wire

// File: rtl/pof_rem.sv
// pof_rem: bit-serial restoring remainder unit, one dividend bit per cycle.
// Computes dividend % divisor over the VALUE_WIDTH-1 dividend bits; divisor held by caller.
// No package dependencies.
`default_nettype none

module pof_rem #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [VALUE_WIDTH-2:0] dividend,
	input  wire logic [VALUE_WIDTH-1:0] divisor,
	output logic                        busy,
	output logic                        rem_zero
);

	localparam int CntW = $clog2(VALUE_WIDTH);

	logic                   busy_q;
	logic [CntW-1:0]        cnt_q;
	logic [VALUE_WIDTH-2:0] dvd_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH:0]   shifted;
	logic [VALUE_WIDTH:0]   diff;
	logic                   fits;

	assign shifted = {rem_q, dvd_q[VALUE_WIDTH-2]};
	assign diff    = shifted - {1'b0, divisor};
	assign fits    = shifted >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntW'(VALUE_WIDTH - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
			dvd_q <= {dvd_q[VALUE_WIDTH-3:0], 1'b0};
		end
	end

	assign busy     = busy_q;
	assign rem_zero = (rem_q == '0);

endmodule

`default_nettype wire

// File: rtl/pof_dp.sv
// pof_dp: datapath of the classifier: operand, trial divisor and its square,
// Fibonacci pair, remainder unit and result register. Uses pof_pkg, pof_rem.
`default_nettype none

module pof_dp
	import pof_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   test_select,
	input  wire logic [VALUE_WIDTH-1:0] value,
	input  wire cmd_t                   cmd,
	output status_t                     st,
	output logic                        verdict
);

	logic                   sel_q;
	logic                   neg_q;
	logic [VALUE_WIDTH-2:0] n_q;
	logic [VALUE_WIDTH-1:0] d_q;
	logic [VALUE_WIDTH:0]   sq_q;   // always d_q * d_q
	logic [VALUE_WIDTH:0]   a_q;
	logic [VALUE_WIDTH:0]   b_q;
	logic                   verdict_q;
	logic [VALUE_WIDTH:0]   n_ext;
	logic                   rem_busy;
	logic                   rem_zero;

	assign n_ext = {2'b00, n_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sel_q <= test_select;
			neg_q <= value[VALUE_WIDTH-1];
			n_q   <= value[VALUE_WIDTH-2:0];
			d_q   <= VALUE_WIDTH'(2);
			sq_q  <= (VALUE_WIDTH + 1)'(4);
			a_q   <= '0;
			b_q   <= (VALUE_WIDTH + 1)'(1);
		end else begin
			if (cmd.next_div) begin
				// (d+1)^2 = d^2 + 2d + 1
				d_q  <= d_q + 1'b1;
				sq_q <= sq_q + {d_q, 1'b1};
			end
			if (cmd.step_fib) begin
				a_q <= b_q;
				b_q <= a_q + b_q;
			end
		end
		if (cmd.set_verdict)
			verdict_q <= cmd.verdict_bit;
	end

	pof_rem #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_rem),
		.dividend (n_q),
		.divisor  (d_q),
		.busy     (rem_busy),
		.rem_zero (rem_zero)
	);

	always_comb begin
		st.sel_fib  = sel_q;
		st.neg      = neg_q;
		st.lt2      = (n_q < (VALUE_WIDTH - 1)'(2));
		st.sq_gt_n  = (sq_q > n_ext);
		st.a_ge_n   = (a_q >= n_ext);
		st.a_eq_n   = (a_q == n_ext);
		st.rem_busy = rem_busy;
		st.rem_zero = rem_zero;
	end

	assign verdict = verdict_q;

endmodule

`default_nettype wire

// File: rtl/pof_ctrl.sv
// pof_ctrl: sequencing state machine and handshakes for the classifier.
// Drives pof_dp through cmd_t and reads its status_t. Uses pof_pkg.
`default_nettype none

module pof_ctrl
	import pof_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	output logic      item_stall,
	output logic      result_valid,
	input  wire logic result_stall,
	input  wire status_t st,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_CHECK = 3'b010,
		S_DIV   = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// Result register is free if empty or being taken this cycle
	assign out_free = !out_valid_q || !result_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.sel_fib) begin
					if (st.neg || st.a_ge_n) begin
						if (out_free) begin
							cmd.set_verdict = 1'b1;
							cmd.verdict_bit = !st.neg && st.a_eq_n;
							state_d         = S_IDLE;
						end
					end else begin
						cmd.step_fib = 1'b1;
					end
				end else if (st.neg || st.lt2 || st.sq_gt_n) begin
					if (out_free) begin
						cmd.set_verdict = 1'b1;
						cmd.verdict_bit = !st.neg && !st.lt2;
						state_d         = S_IDLE;
					end
				end else begin
					cmd.start_rem = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (!st.rem_busy) begin
					if (st.rem_zero) begin
						// divisor found: composite
						if (out_free) begin
							cmd.set_verdict = 1'b1;
							cmd.verdict_bit = 1'b0;
							state_d         = S_IDLE;
						end
					end else begin
						cmd.next_div = 1'b1;
						state_d      = S_CHECK;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.set_verdict)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_verdict |-> (!out_valid_q || !result_stall))
		else $error("result register overwritten before transfer");
	a_rem_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_rem |=> (state_q == S_DIV) && st.rem_busy)
		else $error("remainder unit not running after start");
	a_next_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.next_div |-> (!st.rem_zero && !st.rem_busy))
		else $error("divisor advanced on zero or pending remainder");
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_stall) |=> out_valid_q && !$past(cmd.set_verdict))
		else $error("pending result lost or replaced");
`endif

endmodule

`default_nettype wire

// File: rtl/prime_or_fibonacci_test_top.sv
// Classifier of one signed integer: trial-division primality or Fibonacci
// membership. Input channel: item_valid / item_stall with test_select and
// value (two's complement, VALUE_WIDTH bits). Output channel: result_valid /
// result_stall with verdict, one result per item, in order.
// An item is taken only while the block is idle; the next is taken as soon
// as its result is in the output register, so a waiting result does not
// hold up the input side. A finished item waits in its state until the
// output register is empty or being taken.
// Primality: each trial divisor takes one run of the bit-serial remainder
// unit plus the control states S_CHECK and S_DIV; trial divisors run from
// 2 up to floor(sqrt(n)). Negative values and values below two finish
// without a remainder run.
// Fibonacci: one term per cycle until the term reaches or passes n.
// A stalled result holds verdict and result_valid. Reset clears the
// controller and the output valid; no state is kept between items.
`default_nettype none

module prime_or_fibonacci_test_top
	import pof_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        item_stall,
	input  wire logic                   test_select,
	input  wire logic [VALUE_WIDTH-1:0] value,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output logic                        verdict
);

	cmd_t    cmd;
	status_t st;

	pof_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.st           (st),
		.cmd          (cmd)
	);

	pof_dp #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.test_select (test_select),
		.value       (value),
		.cmd         (cmd),
		.st          (st),
		.verdict     (verdict)
	);

endmodule

`default_nettype wire

// File: bench/pof_test_pkg.sv
`timescale 1ns / 100ps
// pof_test_pkg: test selector codes shared by the classifier bench files.
// No dependencies.

package pof_test_pkg;

	typedef enum logic {
		TEST_PRIME = 1'b0,
		TEST_FIB   = 1'b1
	} test_kind_e;

endpackage

// File: bench/prime_or_fibonacci_test_checker.sv
`timescale 1ns / 100ps
// Scoreboard for prime_or_fibonacci_test_top: predicts the verdict of each input
// transfer and compares it with the result transfers in order. Needs pof_test_pkg.

module prime_or_fibonacci_test_checker
	import pof_test_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic                   item_stall,
	input  logic                   test_select,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  logic                   verdict,
	output int unsigned            fail_count,
	output int unsigned            pending_results
);

	localparam int unsigned REPORT_LIMIT = 10;

	typedef struct packed {
		test_kind_e             kind;
		logic [VALUE_WIDTH-1:0] operand;
		logic                   verdict;
	} verdict_rec_t;

	verdict_rec_t expected_verdicts[$];
	int unsigned  errors = 0;

	// Negative operands fail both tests; the Fibonacci walk runs in 64 bits
	function automatic logic classify_value(test_kind_e kind, logic [VALUE_WIDTH-1:0] v);
		longint unsigned n;
		longint unsigned d;
		longint unsigned a;
		longint unsigned b;
		longint unsigned t;
		n = v;
		if (v[VALUE_WIDTH-1])
			return 1'b0;
		if (kind == TEST_PRIME) begin
			if (n < 2)
				return 1'b0;
			for (d = 2; d <= n / d; d++)
				if (n % d == 0)
					return 1'b0;
			return 1'b1;
		end
		a = 0;
		b = 1;
		while (a < n) begin
			t = a + b;
			a = b;
			b = t;
		end
		return a == n;
	endfunction

	task automatic report_mismatch(string what);
		errors++;
		if (errors <= REPORT_LIMIT)
			$display("[%0t] %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		verdict_rec_t rec;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch($sformatf("result transfer with none pending: verdict %b",
						verdict));
				end else begin
					rec = expected_verdicts.pop_front();
					if (verdict !== rec.verdict)
						report_mismatch($sformatf("%s value %0d: expected %b, got %b",
							rec.kind.name(), $signed(rec.operand), rec.verdict, verdict));
				end
			end
			if (item_valid && !item_stall) begin
				rec.kind    = test_kind_e'(test_select);
				rec.operand = value;
				rec.verdict = classify_value(rec.kind, value);
				expected_verdicts.push_back(rec);
			end
		end
		fail_count      <= errors;
		pending_results <= expected_verdicts.size();
	end

endmodule

// File: bench/prime_or_fibonacci_test_top_tb.sv
`timescale 1ns / 100ps
// Bench top for prime_or_fibonacci_test_top: clock, reset, stimulus and verdict.
// Needs pof_test_pkg, prime_or_fibonacci_test_checker and the RTL.

module prime_or_fibonacci_test_top_tb;
	import pof_test_pkg::*;

	localparam int          VALUE_W        = 32;
	localparam int unsigned TRIAL_CAP      = 300;     // most divisors per random prime test
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned SQUEEZE_ITEMS  = 12;
	localparam int unsigned RANDOM_ITEMS   = 62;
	localparam int unsigned CALM_FROM      = 50;
	localparam int unsigned TAIL_CYCLES    = 40;
	localparam int unsigned WATCHDOG_LIMIT = 200000;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               item_valid   = 1'b0;
	logic               test_select  = 1'b0;
	logic [VALUE_W-1:0] value        = '0;
	logic               result_stall = 1'b0;
	logic               item_stall;
	logic               result_valid;
	logic               verdict;
	int unsigned        fail_count;
	int unsigned        pending_results;
	int unsigned        quiet_cycles = 0;
	bit                 hold_req     = 1'b0;
	bit                 calm         = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	prime_or_fibonacci_test_top #(.VALUE_WIDTH(VALUE_W)) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.test_select (test_select),
		.value       (value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.verdict     (verdict)
	);

	prime_or_fibonacci_test_checker #(.VALUE_WIDTH(VALUE_W)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.test_select    (test_select),
		.value          (value),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.verdict        (verdict),
		.fail_count     (fail_count),
		.pending_results(pending_results)
	);

	// Rough cost of a primality test: number of trial divisors the block will try
	function automatic int unsigned divisor_trials(logic [VALUE_W-1:0] v);
		longint unsigned n;
		longint unsigned d;
		int unsigned     trials;
		n = v;
		trials = 0;
		if (v[VALUE_W-1] || n < 2)
			return 0;
		for (d = 2; d <= n / d; d++) begin
			trials++;
			if (n % d == 0)
				break;
		end
		return trials;
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value(test_kind_e kind);
		logic [VALUE_W-1:0] v;
		longint unsigned    a;
		longint unsigned    b;
		longint unsigned    t;
		int unsigned        w;
		case ($urandom_range(0, 9))
			0: v = $urandom | 32'h8000_0000;
			1: v = $urandom_range(0, 20);
			2, 3, 4: begin
				if (kind == TEST_FIB) begin
					// a Fibonacci term, or one either side of it
					a = 0;
					b = 1;
					repeat ($urandom_range(0, 46)) begin
						t = a + b;
						a = b;
						b = t;
					end
					v = a[VALUE_W-1:0] + VALUE_W'($urandom_range(0, 2)) - 1'b1;
				end else begin
					v = $urandom;
				end
			end
			default: begin
				w = $urandom_range(1, VALUE_W - 1);
				v = $urandom & ((32'd1 << w) - 1);
			end
		endcase
		// values needing over TRIAL_CAP trial divisors are halved until affordable
		if (kind == TEST_PRIME)
			while (divisor_trials(v) > TRIAL_CAP)
				v = v >> 1;
		return v;
	endfunction

	task automatic send_item(test_kind_e kind, logic [VALUE_W-1:0] v);
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		item_valid  <= 1'b1;
		test_select <= kind;
		value       <= v;
		do
			@(posedge clk);
		while (item_stall);
	endtask

	task automatic wait_drained();
		repeat (2) @(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
	endtask

	// Result side: long hold-off on request, otherwise random stall bursts
	initial begin
		int unsigned span;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (calm || $urandom_range(0, 3) != 0) begin
				span = $urandom_range(1, 20);
				result_stall <= 1'b0;
				repeat (span) @(posedge clk);
			end else begin
				span = $urandom_range(1, 7);
				result_stall <= 1'b1;
				repeat (span) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("** prime_or_fibonacci_test_top: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		test_kind_e kind;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// primality: extremes, small cases, squares and moderate primes
		send_item(TEST_PRIME, 32'h8000_0000);
		send_item(TEST_PRIME, 32'hFFFF_FFFF);
		send_item(TEST_PRIME, 32'd0);
		send_item(TEST_PRIME, 32'd1);
		send_item(TEST_PRIME, 32'd2);
		send_item(TEST_PRIME, 32'd3);
		send_item(TEST_PRIME, 32'd4);
		send_item(TEST_PRIME, 32'd25);
		send_item(TEST_PRIME, 32'd49);
		send_item(TEST_PRIME, 32'd65521);
		send_item(TEST_PRIME, 32'd1018081);    // 1009 squared
		send_item(TEST_PRIME, 32'd1000003);
		send_item(TEST_PRIME, 32'd2147483646);
		send_item(TEST_PRIME, 32'd2147483645);
		// Fibonacci: extremes, zero and one, top term of the width and beyond
		send_item(TEST_FIB, 32'h8000_0000);
		send_item(TEST_FIB, 32'hFFFF_FFFF);
		send_item(TEST_FIB, 32'd0);
		send_item(TEST_FIB, 32'd1);
		send_item(TEST_FIB, 32'd2);
		send_item(TEST_FIB, 32'd4);
		send_item(TEST_FIB, 32'd144);
		send_item(TEST_FIB, 32'd145);
		send_item(TEST_FIB, 32'd1134903170);
		send_item(TEST_FIB, 32'd1836311903);
		send_item(TEST_FIB, 32'd1836311904);
		send_item(TEST_FIB, 32'd2147483647);
		item_valid <= 1'b0;
		wait_drained();

		// back-pressure: output held off while quick items keep coming
		hold_req = 1'b1;
		repeat (SQUEEZE_ITEMS)
			send_item(TEST_FIB, VALUE_W'($urandom_range(0, 1000)));

		for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == CALM_FROM)
				calm = 1'b1;
			kind = test_kind_e'($urandom_range(0, 1));
			send_item(kind, pick_value(kind));
		end
		item_valid <= 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("** prime_or_fibonacci_test_top: PASSED **");
		else
			$display("** prime_or_fibonacci_test_top: FAILED **");
		$finish;
	end

endmodule

// File: sim.f
rtl/pof_pkg.sv
rtl/pof_rem.sv
rtl/pof_dp.sv
rtl/pof_ctrl.sv
rtl/prime_or_fibonacci_test_top.sv
bench/pof_test_pkg.sv
bench/prime_or_fibonacci_test_checker.sv
bench/prime_or_fibonacci_test_top_tb.sv
